FILE: sv/htsc_pkg.sv
`timescale 1ns / 1ps

package htsc_pkg;

  localparam int SampleBits = 12;
  localparam int LevelBits  = 8;
  localparam int PosBits    = $clog2(LevelBits);
  localparam int KdBits     = LevelBits + SampleBits;
  localparam int ProdBits   = 2 * LevelBits + SampleBits;
  localparam int FullScale  = (1 << LevelBits) - 1;
  localparam int DeadDiv    = 40;
  localparam int DeadBits   = SampleBits + $clog2(DeadDiv);
  localparam int NumCells   = LevelBits;

  localparam logic [SampleBits-1:0] MaxReset = SampleBits'((1 << SampleBits) - 1);

  localparam logic [2:0] RegLeftMin  = 3'd0;
  localparam logic [2:0] RegLeftMax  = 3'd1;
  localparam logic [2:0] RegRightMin = 3'd2;
  localparam logic [2:0] RegRightMax = 3'd3;
  localparam logic [2:0] RegCal      = 3'd4;

  typedef struct packed {
    logic [SampleBits-1:0] left_min;
    logic [SampleBits-1:0] left_max;
    logic [SampleBits-1:0] right_min;
    logic [SampleBits-1:0] right_max;
    logic                  calibrated;
  } htsc_cfg_t;

  typedef struct packed {
    logic                  fixed;
    logic [LevelBits-1:0]  k;
    logic [KdBits-1:0]     kd;
    logic [ProdBits-1:0]   k2d;
    logic [SampleBits-1:0] den;
    logic [ProdBits-1:0]   target;
  } htsc_cell_t;

endpackage

FILE: sv/htsc_regs.sv
`timescale 1ns / 1ps

module htsc_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output htsc_pkg::htsc_cfg_t cfg_o
);
  import htsc_pkg::*;

  htsc_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_min   <= '0;
      cfg_q.left_max   <= MaxReset;
      cfg_q.right_min  <= '0;
      cfg_q.right_max  <= MaxReset;
      cfg_q.calibrated <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        RegLeftMin:  cfg_q.left_min   <= pwdata[SampleBits-1:0];
        RegLeftMax:  cfg_q.left_max   <= pwdata[SampleBits-1:0];
        RegRightMin: cfg_q.right_min  <= pwdata[SampleBits-1:0];
        RegRightMax: cfg_q.right_max  <= pwdata[SampleBits-1:0];
        RegCal:      cfg_q.calibrated <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegLeftMin:  prdata = 32'(cfg_q.left_min);
      RegLeftMax:  prdata = 32'(cfg_q.left_max);
      RegRightMin: prdata = 32'(cfg_q.right_min);
      RegRightMax: prdata = 32'(cfg_q.right_max);
      RegCal:      prdata = 32'(cfg_q.calibrated);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: sv/htsc_front.sv
`timescale 1ns / 1ps

module htsc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [htsc_pkg::SampleBits-1:0] sample_i,
  input  logic                          side_i,
  input  htsc_pkg::htsc_cfg_t           cfg_i,
  output logic                          valid_o,
  output htsc_pkg::htsc_cell_t          d_o
);
  import htsc_pkg::*;

  logic                  a_valid_q;
  logic                  a_cal_q, a_below_q, a_above_q;
  logic [SampleBits-1:0] a_num_q, a_den_q;
  logic [LevelBits-1:0]  a_uncal_q;
  logic [SampleBits-1:0] lo, hi;

  logic                  b_valid_q;
  htsc_cell_t            b_q, b_d;
  logic [DeadBits-1:0]   dead_num;
  logic                  dead;

  always_comb begin
    lo = side_i ? cfg_i.right_min : cfg_i.left_min;
    hi = side_i ? cfg_i.right_max : cfg_i.left_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_cal_q   <= cfg_i.calibrated;
      a_below_q <= sample_i < lo;
      a_above_q <= sample_i >= hi;
      a_num_q   <= sample_i - lo;
      a_den_q   <= hi - lo;
      a_uncal_q <= sample_i[SampleBits-1 -: LevelBits];
      b_q       <= b_d;
    end
  end

  always_comb begin
    dead_num = DeadBits'(a_num_q) * DeadBits'(DeadDiv);
    dead     = dead_num < DeadBits'(a_den_q);
    b_d.fixed  = !a_cal_q || a_below_q || a_above_q || dead;
    b_d.kd     = '0;
    b_d.k2d    = '0;
    b_d.den    = a_den_q;
    b_d.target = ProdBits'(a_num_q) * ProdBits'(FullScale * FullScale);
    if (!a_cal_q) begin
      b_d.k = a_uncal_q;
    end else if (a_below_q) begin
      b_d.k = '0;
    end else if (a_above_q) begin
      b_d.k = LevelBits'(FullScale);
    end else begin
      b_d.k = '0;
    end
  end

  assign valid_o = b_valid_q;
  assign d_o     = b_q;

endmodule

FILE: sv/htsc_cell.sv
`timescale 1ns / 1ps

module htsc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [htsc_pkg::PosBits-1:0] pos_i,
  input  logic                        valid_i,
  input  htsc_pkg::htsc_cell_t        d_i,
  output logic                        valid_o,
  output htsc_pkg::htsc_cell_t        d_o
);
  import htsc_pkg::*;

  logic                valid_q;
  htsc_cell_t          d_q, nxt;
  logic [ProdBits-1:0] cand;
  logic [PosBits:0]    sh_kd, sh_den;
  logic                take;

  always_comb begin
    sh_kd  = (PosBits+1)'(pos_i) + (PosBits+1)'(1);
    sh_den = {pos_i, 1'b0};
    cand   = d_i.k2d + (ProdBits'(d_i.kd) << sh_kd) + (ProdBits'(d_i.den) << sh_den);
    take   = !d_i.fixed && (cand <= d_i.target);
    nxt    = d_i;
    if (take) begin
      nxt.k   = d_i.k | (LevelBits'(1) << pos_i);
      nxt.k2d = cand;
      nxt.kd  = d_i.kd + (KdBits'(d_i.den) << pos_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

FILE: sv/hall_trigger_sqrt_curve.sv
`timescale 1ns / 1ps
// Datapath: two front stages, eight root cells deciding one level bit each, and one output
// register lie between accepting a sample word and offering its level word; the first front
// stage loads at the edge that accepts the sample word.
// Throughput: one word per cycle while the skid register (one backpressured result) is empty.
// Reset: asynchronous, active low; clears all valid flags and loads the register reset values.

module hall_trigger_sqrt_curve (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
  input  logic        s_axis_tuser,  // [0] side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] level
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import htsc_pkg::*;

  htsc_cfg_t            cfg;
  logic                 en;
  logic                 chain_v [NumCells+1];
  htsc_cell_t           chain_d [NumCells+1];

  logic                 out_v_q, skid_v_q;
  logic [LevelBits-1:0] out_q, skid_q;
  logic                 last_v;
  logic [LevelBits-1:0] last_k;

  htsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  htsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .sample_i (s_axis_tdata[SampleBits-1:0]),
    .side_i   (s_axis_tuser),
    .cfg_i    (cfg),
    .valid_o  (chain_v[0]),
    .d_o      (chain_d[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    htsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .pos_i   (PosBits'(LevelBits - 1 - i)),
      .valid_i (chain_v[i]),
      .d_i     (chain_d[i]),
      .valid_o (chain_v[i+1]),
      .d_o     (chain_d[i+1])
    );
  end

  assign last_v = chain_v[NumCells];
  assign last_k = chain_d[NumCells].k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (out_v_q && !m_axis_tready) begin
      skid_v_q <= last_v;
    end else begin
      out_v_q <= last_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (out_v_q && !m_axis_tready) begin
      skid_q <= last_k;
    end else begin
      out_q <= last_k;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule
